// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL of the point splat block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, switched off while rst is high.
`define BPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset cycles included.
`define BPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/bps_pkg.sv -----
// Shared constants and helpers of the bilinear point splat block.
package bps_pkg;

  localparam int COLOR_W = 16;
  localparam int SUM_W   = 32;
  localparam int SHARE_W = COLOR_W + 1;

  typedef logic [1:0] status_t;

  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_DROP = 2'd1;
  localparam status_t ST_READ = 2'd2;

  // Adds a weighted color share to an accumulator, clamping at all ones.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]   acc,
                                                input logic [SHARE_W-1:0] share);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W + 1)'(share);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

endpackage

// ----- hdl/bilinear_point_splat_core.sv -----
// Bilinear point splat core: accumulates weighted color points in an RGB pixel store.
//
//   channel  direction  handshake              payload
//   -------  ---------  ---------------------  ---------------------------------------
//   in       in         in_valid / in_stall    action, pos_x, pos_y, color_red/green/blue
//   out      out        out_valid / out_stall  status, sum_red, sum_green, sum_blue
//   cfg      in         APB psel/penable       image_width (0x0), image_height (0x4)
//
// A splat item works through its four pixels in turn, each on the single multiplier and
// the one-port-pair pixel memory (weight, red, green, blue, write back). A read item reads
// its pixel, a dropped splat goes straight to its result; the next item waits meanwhile.
// After rst the whole store is cleared, one pixel a cycle, all MAX_WIDTH*MAX_HEIGHT
// pixels (16384 with the defaults); in_stall stays high during that pass, while
// configuration writes are taken as usual. A finished result waits in the output
// register while out_stall is high; the next item is accepted meanwhile and its own
// result is held back until the output register is free.
module bilinear_point_splat_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  // item input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0] color_red,
  input  logic [15:0] color_green,
  input  logic [15:0] color_blue,
  // result output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] sum_red,
  output logic [31:0] sum_green,
  output logic [31:0] sum_blue,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  // Store geometry: pixel (x,y) sits at word y*MAX_WIDTH + x.
  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(PIXELS);
  // Integer part of a non-negative position.
  localparam int IW     = 15 - FRAC_BITS;
  // Size registers must hold their reset value as well as any 8-bit write.
  localparam int WW     = ($clog2(MAX_WIDTH + 1) > 8) ? $clog2(MAX_WIDTH + 1) : 8;
  localparam int HW     = ($clog2(MAX_HEIGHT + 1) > 8) ? $clog2(MAX_HEIGHT + 1) : 8;
  localparam int CW0    = (IW > WW) ? IW : WW;
  localparam int CW     = ((CW0 > HW) ? CW0 : HW) + 1;
  // Weights carry 2*FRAC_BITS fraction bits and reach S*S.
  localparam int WB     = 2 * FRAC_BITS + 1;
  localparam int PW     = bps_pkg::COLOR_W + WB;
  localparam int MW     = 3 * bps_pkg::SUM_W;
  localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_ADDR,
    S_RD_DATA,
    S_WGT,
    S_MR,
    S_MG,
    S_MB,
    S_WR,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [WW-1:0] image_width;
  logic [HW-1:0] image_height;
  logic [WW-1:0] width_next;
  logic [HW-1:0] height_next;
  logic [7:0]    wr_val;
  logic          cfg_write;

  // Item registers.
  logic [AW-1:0]        base;
  logic [1:0]           pix_k;
  logic [FRAC_BITS-1:0] frac_x;
  logic [FRAC_BITS-1:0] frac_y;
  logic [15:0]          col_r;
  logic [15:0]          col_g;
  logic [15:0]          col_b;
  logic [WB-1:0]        weight;
  logic [PW-1:0]        prod;
  logic [31:0]          acc_red;
  logic [31:0]          acc_green;
  logic [AW-1:0]        clr_addr;

  // Pending result, handed to the output register in S_FINISH.
  bps_pkg::status_t res_status;
  logic [31:0]      res_red;
  logic [31:0]      res_green;
  logic [31:0]      res_blue;

  // Decode of the incoming item.
  logic          pos_neg;
  logic [IW-1:0] xi;
  logic [IW-1:0] yi;
  logic          read_inside;
  logic          splat_inside;
  logic [AW-1:0] base_next;

  // Shared multiplier.
  logic [15:0]          mult_a;
  logic [WB-1:0]        mult_b;
  logic [PW-1:0]        mult_p;
  logic [FRAC_BITS:0]   sel_x;
  logic [FRAC_BITS:0]   sel_y;
  logic [bps_pkg::SHARE_W-1:0] share;

  // Pixel memory: red, green and blue of one pixel in one word.
  logic [MW-1:0] mem [PIXELS];
  logic [MW-1:0] mem_rdata;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] pix_addr;
  logic          mem_we;
  logic          mem_re;

  // ---------------------------------------------------------------------------
  // Configuration port. Only bit 2 of the address selects a register.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign wr_val    = pwdata[7:0];
  assign prdata    = paddr[2] ? 32'(image_height) : 32'(image_width);

  // Written sizes are clamped to the range 2 up to the store's maximum.
  always_comb begin
    if (wr_val < 8'd2) begin
      width_next  = WW'(2);
      height_next = HW'(2);
    end else begin
      if (CW'(wr_val) > CW'(MAX_WIDTH)) begin
        width_next = WW'(MAX_WIDTH);
      end else begin
        width_next = WW'(wr_val);
      end
      if (CW'(wr_val) > CW'(MAX_HEIGHT)) begin
        height_next = HW'(MAX_HEIGHT);
      end else begin
        height_next = HW'(wr_val);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item decode. Any negative coordinate is outside the image; a splat also
  // needs its right and lower neighbors inside.
  // ---------------------------------------------------------------------------
  assign pos_neg      = pos_x[15] || pos_y[15];
  assign xi           = pos_x[14:FRAC_BITS];
  assign yi           = pos_y[14:FRAC_BITS];
  assign read_inside  = !pos_neg && (CW'(xi) < CW'(image_width)) &&
                        (CW'(yi) < CW'(image_height));
  assign splat_inside = !pos_neg && (CW'(xi) + CW'(1) < CW'(image_width)) &&
                        (CW'(yi) + CW'(1) < CW'(image_height));
  assign base_next    = AW'(yi) * AW'(MAX_WIDTH) + AW'(xi);

  // The four pixels in order: top left, top right, bottom left, bottom right.
  always_comb begin
    case (pix_k)
      2'd0:    pix_addr = base;
      2'd1:    pix_addr = base + AW'(1);
      2'd2:    pix_addr = base + AW'(MAX_WIDTH);
      2'd3:    pix_addr = base + AW'(MAX_WIDTH + 1);
      default: pix_addr = base;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier. In S_WGT it forms the bilinear weight of the current
  // pixel, then it scales red, green and blue by that weight in turn.
  // ---------------------------------------------------------------------------
  assign sel_x = pix_k[0] ? {1'b0, frac_x} : ONE_FX - {1'b0, frac_x};
  assign sel_y = pix_k[1] ? {1'b0, frac_y} : ONE_FX - {1'b0, frac_y};

  always_comb begin
    case (state)
      S_WGT: begin
        mult_a = 16'(sel_x);
        mult_b = WB'(sel_y);
      end
      S_MR: begin
        mult_a = col_r;
        mult_b = weight;
      end
      S_MG: begin
        mult_a = col_g;
        mult_b = weight;
      end
      S_MB: begin
        mult_a = col_b;
        mult_b = weight;
      end
      default: begin
        mult_a = '0;
        mult_b = '0;
      end
    endcase
  end

  assign mult_p = PW'(mult_a) * PW'(mult_b);
  assign share  = prod[2*FRAC_BITS +: bps_pkg::SHARE_W];

  // ---------------------------------------------------------------------------
  // Pixel memory ports.
  // ---------------------------------------------------------------------------
  assign mem_re    = (state == S_WGT) || (state == S_RD_ADDR);
  assign mem_we    = (state == S_CLEAR) || (state == S_WR);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : pix_addr;
  assign mem_wdata = (state == S_CLEAR) ? '0 :
                     {acc_red, acc_green,
                      bps_pkg::sat_add(mem_rdata[bps_pkg::SUM_W-1:0], share)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[pix_addr];
    end
  end

  assign in_stall = (state != S_IDLE);

  // ---------------------------------------------------------------------------
  // Sequencer with the configuration, item and output registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      image_width  <= WW'(MAX_WIDTH);
      image_height <= HW'(MAX_HEIGHT);
    end else begin
      if (cfg_write) begin
        if (paddr[2]) begin
          image_height <= height_next;
        end else begin
          image_width <= width_next;
        end
      end

      // In S_FINISH the output register is reloaded instead of emptied.
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(PIXELS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            base       <= base_next;
            pix_k      <= 2'd0;
            frac_x     <= pos_x[FRAC_BITS-1:0];
            frac_y     <= pos_y[FRAC_BITS-1:0];
            col_r      <= color_red;
            col_g      <= color_green;
            col_b      <= color_blue;
            res_red    <= '0;
            res_green  <= '0;
            res_blue   <= '0;
            if (action) begin
              res_status <= bps_pkg::ST_READ;
              state      <= read_inside ? S_RD_ADDR : S_FINISH;
            end else if (splat_inside) begin
              res_status <= bps_pkg::ST_DONE;
              state      <= S_WGT;
            end else begin
              res_status <= bps_pkg::ST_DROP;
              state      <= S_FINISH;
            end
          end
        end

        S_RD_ADDR: begin
          state <= S_RD_DATA;
        end

        S_RD_DATA: begin
          res_red   <= mem_rdata[3*bps_pkg::SUM_W-1:2*bps_pkg::SUM_W];
          res_green <= mem_rdata[2*bps_pkg::SUM_W-1:bps_pkg::SUM_W];
          res_blue  <= mem_rdata[bps_pkg::SUM_W-1:0];
          state     <= S_FINISH;
        end

        S_WGT: begin
          weight <= mult_p[WB-1:0];
          state  <= S_MR;
        end

        S_MR: begin
          prod  <= mult_p;
          state <= S_MG;
        end

        S_MG: begin
          prod    <= mult_p;
          acc_red <= bps_pkg::sat_add(mem_rdata[3*bps_pkg::SUM_W-1:2*bps_pkg::SUM_W],
                                      share);
          state   <= S_MB;
        end

        S_MB: begin
          prod      <= mult_p;
          acc_green <= bps_pkg::sat_add(mem_rdata[2*bps_pkg::SUM_W-1:bps_pkg::SUM_W],
                                        share);
          state     <= S_WR;
        end

        S_WR: begin
          if (pix_k == 2'd3) begin
            state <= S_FINISH;
          end else begin
            pix_k <= pix_k + 2'd1;
            state <= S_WGT;
          end
        end

        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res_status;
            sum_red   <= res_red;
            sum_green <= res_green;
            sum_blue  <= res_blue;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `BPS_ASSERT_ALWAYS(a_clear_blocks_input, rst |=> in_stall, "item taken before the store was cleared")
  `BPS_ASSERT(a_rdata_held, (state == S_MG || state == S_MB || state == S_WR) |-> $stable(mem_rdata), "pixel read data changed during its update")
  `BPS_ASSERT(a_last_pixel_ends, (state == S_WR && pix_k == 2'd3) |=> state == S_FINISH, "splat did not end after its fourth pixel")
  `BPS_ASSERT(a_splat_sums_zero, (out_valid && status != bps_pkg::ST_READ) |-> (sum_red == '0 && sum_green == '0 && sum_blue == '0), "splat result carries nonzero sums")
  `BPS_ASSERT(a_result_waits, (state == S_FINISH && out_valid && out_stall) |=> (state == S_FINISH && $stable(res_status)), "result overwrote a waiting output")

endmodule

// ----- tb/sv/tb_bilinear_point_splat_core.sv -----
// Self-checking testbench for the bilinear point splat core: directed, saturation and random.
module tb_bilinear_point_splat_core;

  // Block parameters; the testbench keeps its own copy of the pixel store at these sizes.
  localparam int MAX_W  = 128;
  localparam int MAX_H  = 128;
  localparam int FRAC   = 8;
  localparam int ONE    = 1 << FRAC;
  localparam int PIXELS = MAX_W * MAX_H;

  // The longest quiet stretch of a correct run is the clearing pass after reset
  // (one pixel a cycle, 16384 pixels). A splat item and the random gaps and stalls
  // are far shorter, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 80000;
  // Time allowed after the last expected result for any stray one to show.
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_PRINTED    = 50;

  localparam logic       ACT_SPLAT = 1'b0;
  localparam logic       ACT_READ  = 1'b1;
  localparam logic [2:0] ADDR_IMAGE_WIDTH  = 3'h0;
  localparam logic [2:0] ADDR_IMAGE_HEIGHT = 3'h4;

  typedef struct packed {
    logic              action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]       color_red;
    logic [15:0]       color_green;
    logic [15:0]       color_blue;
  } point_item_t;

  typedef struct packed {
    bps_pkg::status_t status;
    logic [31:0]      sum_red;
    logic [31:0]      sum_green;
    logic [31:0]      sum_blue;
  } pixel_sum_t;

  // Every input of the block starts at a known value.
  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               action      = ACT_SPLAT;
  logic signed [15:0] pos_x       = '0;
  logic signed [15:0] pos_y       = '0;
  logic [15:0]        color_red   = '0;
  logic [15:0]        color_green = '0;
  logic [15:0]        color_blue  = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [1:0]         status;
  logic [31:0]        sum_red;
  logic [31:0]        sum_green;
  logic [31:0]        sum_blue;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [2:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predicted pixel store and image size, in step with the block.
  logic [31:0] acc_red   [PIXELS];
  logic [31:0] acc_green [PIXELS];
  logic [31:0] acc_blue  [PIXELS];
  int img_w = MAX_W;
  int img_h = MAX_H;

  pixel_sum_t expected_sums[$];

  int in_idle_pct   = 13;
  int out_stall_pct = 13;
  int errors        = 0;
  int idle_cycles   = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_added       = 0;
  int n_dropped     = 0;
  int n_reads       = 0;
  int n_settings    = 0;
  int last_x        = 0;
  int last_y        = 0;

  bilinear_point_splat_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .FRAC_BITS  (FRAC)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .color_red   (color_red),
    .color_green (color_green),
    .color_blue  (color_blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .sum_red     (sum_red),
    .sum_green   (sum_green),
    .sum_blue    (sum_blue),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Register values are taken from the low byte and clamped to [2, max].
  function automatic int clamp_dim(logic [31:0] raw, int maxv);
    int t;
    t = raw[7:0];
    if (t < 2) return 2;
    if (t > maxv) return maxv;
    return t;
  endfunction

  // Adds (color * weight) >> 2*FRAC to one accumulator, clamping at all ones.
  function automatic logic [31:0] accumulate_channel(logic [31:0] acc, logic [15:0] color,
                                                     int weight);
    longint share;
    longint total;
    share = (longint'(color) * longint'(weight)) >> (2 * FRAC);
    total = longint'(acc) + share;
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  function automatic void splat_pixel(int idx, point_item_t it, int weight);
    acc_red[idx]   = accumulate_channel(acc_red[idx], it.color_red, weight);
    acc_green[idx] = accumulate_channel(acc_green[idx], it.color_green, weight);
    acc_blue[idx]  = accumulate_channel(acc_blue[idx], it.color_blue, weight);
  endfunction

  // Works out the result of one accepted item and updates the predicted store.
  function automatic pixel_sum_t predict_point(point_item_t it);
    pixel_sum_t res;
    int px, py, xi, yi, fx, fy, base;
    res = '0;
    px  = int'($signed(it.pos_x));
    py  = int'($signed(it.pos_y));
    xi  = px >>> FRAC;
    yi  = py >>> FRAC;
    if (it.action == ACT_READ) begin
      // A read outside the image, negative coordinates included, answers zero sums.
      res.status = bps_pkg::ST_READ;
      if (px >= 0 && py >= 0 && xi < img_w && yi < img_h) begin
        base          = yi * MAX_W + xi;
        res.sum_red   = acc_red[base];
        res.sum_green = acc_green[base];
        res.sum_blue  = acc_blue[base];
      end
    end else if (px < 0 || py < 0 || xi + 1 >= img_w || yi + 1 >= img_h) begin
      // Any negative coordinate, or a 2x2 neighborhood past the image edge.
      res.status = bps_pkg::ST_DROP;
    end else begin
      res.status = bps_pkg::ST_DONE;
      fx   = px & (ONE - 1);
      fy   = py & (ONE - 1);
      base = yi * MAX_W + xi;
      splat_pixel(base,             it, (ONE - fx) * (ONE - fy));
      splat_pixel(base + 1,         it, fx * (ONE - fy));
      splat_pixel(base + MAX_W,     it, (ONE - fx) * fy);
      splat_pixel(base + MAX_W + 1, it, fx * fy);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] fx_pos(int whole, int frac);
    return 16'((whole << FRAC) | frac);
  endfunction

  function automatic point_item_t make_point(logic act, logic [15:0] x, logic [15:0] y,
                                             logic [15:0] r, logic [15:0] g, logic [15:0] b);
    point_item_t it;
    it.action      = act;
    it.pos_x       = x;
    it.pos_y       = y;
    it.color_red   = r;
    it.color_green = g;
    it.color_blue  = b;
    return it;
  endfunction

  // Mostly fully random colors, with the extremes and one unit mixed in.
  function automatic logic [15:0] rand_color();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0100;
      default: return 16'($urandom());
    endcase
  endfunction

  // Random item: mostly in-range splats and reads near them, the rest noise.
  function automatic point_item_t rand_point();
    point_item_t it;
    int sel, xi, yi;
    sel = $urandom_range(0, 99);
    it  = make_point(ACT_SPLAT, '0, '0, rand_color(), rand_color(), rand_color());
    if (sel < 55) begin
      xi       = $urandom_range(0, img_w - 2);
      yi       = $urandom_range(0, img_h - 2);
      it.pos_x = fx_pos(xi, $urandom_range(0, ONE - 1));
      it.pos_y = fx_pos(yi, $urandom_range(0, ONE - 1));
      last_x   = xi;
      last_y   = yi;
    end else if (sel < 80) begin
      it.action = ACT_READ;
      if ($urandom_range(0, 1) == 0) begin
        xi = last_x + $urandom_range(0, 1);
        yi = last_y + $urandom_range(0, 1);
      end else begin
        // The size itself is included, so some reads fall just outside the image.
        xi = $urandom_range(0, img_w);
        yi = $urandom_range(0, img_h);
      end
      it.pos_x = fx_pos(xi, $urandom_range(0, ONE - 1));
      it.pos_y = fx_pos(yi, $urandom_range(0, ONE - 1));
    end else begin
      it.action = 1'($urandom());
      it.pos_x  = 16'($urandom());
      it.pos_y  = 16'($urandom());
    end
    return it;
  endfunction

  // Offers one item, with a random gap first, and records its prediction once taken.
  // The valid stays high after acceptance so back-to-back items need no extra edge.
  task automatic send_point(point_item_t it);
    pixel_sum_t res;
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= it.action;
    pos_x       <= it.pos_x;
    pos_y       <= it.pos_y;
    color_red   <= it.color_red;
    color_green <= it.color_green;
    color_blue  <= it.color_blue;
    do @(posedge clk); while (in_stall);
    res = predict_point(it);
    expected_sums.push_back(res);
    n_sent++;
    case (res.status)
      bps_pkg::ST_DONE: n_added++;
      bps_pkg::ST_DROP: n_dropped++;
      default: n_reads++;
    endcase
  endtask

  // Lowers valid and waits until every predicted result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Setup phase, access phase, then an idle gap so transfers never touch.
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      ADDR_IMAGE_WIDTH:  img_w = clamp_dim(data, MAX_W);
      ADDR_IMAGE_HEIGHT: img_h = clamp_dim(data, MAX_H);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic set_image(logic [31:0] w_raw, logic [31:0] h_raw);
    drain_results();
    apb_write(ADDR_IMAGE_WIDTH, w_raw);
    apb_write(ADDR_IMAGE_HEIGHT, h_raw);
    n_settings++;
  endtask

  task automatic report_mismatch(string msg);
    if (errors < MAX_PRINTED) $display("mismatch: %s", msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall, result check, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk) begin
    pixel_sum_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("result with status %0d while no item was pending", status));
      end else begin
        want = expected_sums.pop_front();
        n_checked++;
        if (status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    n_checked, status, want.status));
        if (sum_red !== want.sum_red)
          report_mismatch($sformatf("result %0d sum_red %h, want %h",
                                    n_checked, sum_red, want.sum_red));
        if (sum_green !== want.sum_green)
          report_mismatch($sformatf("result %0d sum_green %h, want %h",
                                    n_checked, sum_green, want.sum_green));
        if (sum_blue !== want.sum_blue)
          report_mismatch($sformatf("result %0d sum_blue %h, want %h",
                                    n_checked, sum_blue, want.sum_blue));
      end
    end
  end

  // Counts cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake, %0d results outstanding",
               idle_cycles, expected_sums.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The store must read back as zero after the clearing pass.
  task automatic test_cleared_store();
    send_point(make_point(ACT_READ, fx_pos(0, 0), fx_pos(0, 0), '1, '1, '1));
    send_point(make_point(ACT_READ, fx_pos(127, 0), fx_pos(127, 0), '0, '0, '0));
  endtask

  // Default 128x128 image: weights, borders, negative positions and read corners.
  task automatic test_splat_edges();
    // Whole-pixel splat puts the full color on one pixel.
    send_point(make_point(ACT_SPLAT, fx_pos(0, 0), fx_pos(0, 0), '1, '1, '1));
    send_point(make_point(ACT_READ, fx_pos(0, 0), fx_pos(0, 0), '0, '0, '0));
    // Fractional splat spread over four pixels, then each one read back.
    send_point(make_point(ACT_SPLAT, fx_pos(1, 8'h80), fx_pos(2, 8'h40),
                          16'h1234, 16'hFFFF, 16'h0001));
    send_point(make_point(ACT_READ, fx_pos(1, 0), fx_pos(2, 0), '0, '0, '0));
    send_point(make_point(ACT_READ, fx_pos(2, 0), fx_pos(2, 0), '0, '0, '0));
    send_point(make_point(ACT_READ, fx_pos(1, 0), fx_pos(3, 0), '0, '0, '0));
    send_point(make_point(ACT_READ, fx_pos(2, 0), fx_pos(3, 0), '0, '0, '0));
    // The last neighborhood that still fits, with the largest fractions.
    send_point(make_point(ACT_SPLAT, fx_pos(126, 8'hFF), fx_pos(126, 8'hFF),
                          16'hFFFF, 16'h8000, 16'h00FF));
    send_point(make_point(ACT_READ, fx_pos(127, 0), fx_pos(127, 0), '0, '0, '0));
    // Neighborhood past the right and bottom edges.
    send_point(make_point(ACT_SPLAT, fx_pos(127, 0), fx_pos(0, 0), '1, '1, '1));
    send_point(make_point(ACT_SPLAT, fx_pos(0, 0), fx_pos(127, 0), '1, '1, '1));
    // Negative coordinates, the smallest fraction below zero among them, and the largest positive position.
    send_point(make_point(ACT_SPLAT, 16'hFFFF, fx_pos(3, 0), '1, '1, '1));
    send_point(make_point(ACT_SPLAT, 16'h8000, 16'h8000, '1, '1, '1));
    send_point(make_point(ACT_SPLAT, fx_pos(3, 0), 16'hFF00, '1, '1, '1));
    send_point(make_point(ACT_SPLAT, 16'h7FFF, 16'h7FFF, '1, '1, '1));
    // Reads at a negative position and at the largest positive one.
    send_point(make_point(ACT_READ, 16'hFFFF, fx_pos(0, 0), '0, '0, '0));
    send_point(make_point(ACT_READ, 16'h7FFF, 16'h7FFF, '0, '0, '0));
    // A splat of zero color changes nothing but still completes.
    send_point(make_point(ACT_SPLAT, fx_pos(5, 8'h33), fx_pos(6, 8'hCC), '0, '0, '0));
  endtask

  // Register values below 2 and above the maximum, with junk in the upper bits.
  task automatic test_register_clamp();
    set_image(32'h0000_0000, 32'h0000_0001);
    send_point(make_point(ACT_SPLAT, fx_pos(0, 8'h80), fx_pos(0, 8'h80), '1, 16'h4000, '1));
    send_point(make_point(ACT_SPLAT, fx_pos(1, 0), fx_pos(0, 0), '1, '1, '1));
    send_point(make_point(ACT_READ, fx_pos(1, 0), fx_pos(1, 0), '0, '0, '0));
    send_point(make_point(ACT_READ, fx_pos(2, 0), fx_pos(0, 0), '0, '0, '0));
    set_image(32'hABCD_0003, 32'h0000_0102);
    send_point(make_point(ACT_SPLAT, fx_pos(1, 8'h10), fx_pos(0, 8'hF0), 16'h0F0F, '1, '1));
    send_point(make_point(ACT_READ, fx_pos(2, 0), fx_pos(1, 0), '0, '0, '0));
    send_point(make_point(ACT_READ, fx_pos(3, 0), fx_pos(0, 0), '0, '0, '0));
    set_image(32'hFFFF_FFFF, 32'h0000_00C8);
    send_point(make_point(ACT_READ, fx_pos(127, 0), fx_pos(127, 0), '0, '0, '0));
  endtask

  // Filling a pixel to all ones through the port would take some 65537 splats, so
  // the clamping add of the store is checked directly near the top of its range.
  // After that comes the long stretch with neither side idling, on pixel (0,0).
  task automatic test_saturation();
    logic [31:0] acc;
    logic [15:0] part;
    logic [31:0] got;
    logic [31:0] want;
    set_image(32'd128, 32'd128);
    for (int i = 0; i < 64; i++) begin
      case (i)
        0: begin
          acc  = 32'hFFFF_FFFF;
          part = 16'hFFFF;
        end
        1: begin
          acc  = 32'hFFFF_0000;
          part = 16'hFFFF;
        end
        default: begin
          acc  = 32'hFFFF_FFFF - 32'($urandom_range(0, 2 * 65535));
          part = 16'($urandom());
        end
      endcase
      got  = bps_pkg::sat_add(acc, bps_pkg::SHARE_W'(part));
      want = accumulate_channel(acc, part, ONE * ONE);
      if (got !== want)
        report_mismatch($sformatf("clamping add of %h and %h gave %h, want %h",
                                  acc, part, got, want));
    end
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (16) begin
      send_point(make_point(ACT_SPLAT, fx_pos(0, 0), fx_pos(0, 0), '1, '1, '1));
    end
    send_point(make_point(ACT_READ, fx_pos(0, 0), fx_pos(0, 0), '0, '0, '0));
    send_point(make_point(ACT_READ, fx_pos(1, 0), fx_pos(0, 0), '0, '0, '0));
  endtask

  // One image setting, then random traffic; optionally the sender waits for
  // every result halfway through.
  task automatic test_random_traffic(logic [31:0] w_raw, logic [31:0] h_raw, int count,
                                     int idle_pct, bit pause_mid);
    set_image(w_raw, h_raw);
    in_idle_pct   = idle_pct;
    out_stall_pct = idle_pct;
    last_x        = 0;
    last_y        = 0;
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) drain_results();
      send_point(rand_point());
    end
  endtask

  initial begin
    for (int i = 0; i < PIXELS; i++) begin
      acc_red[i]   = '0;
      acc_green[i] = '0;
      acc_blue[i]  = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cleared_store();
    test_splat_edges();
    test_register_clamp();
    test_saturation();
    test_random_traffic(32'd128, 32'd128, 140, 13, 1'b0);
    test_random_traffic(32'd2, 32'd2, 140, 13, 1'b0);
    test_random_traffic(32'd5, 32'd3, 140, 13, 1'b1);
    test_random_traffic($urandom(), $urandom(), 140, 13, 1'b0);
    test_random_traffic(32'd128, 32'd2, 140, 0, 1'b0);
    test_random_traffic(32'd2, 32'd128, 140, 13, 1'b1);

    // Let the last results drain, then allow for anything stray.
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_sums.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_sums.size()));

    $display("summary: %0d items sent, %0d results checked over %0d image settings",
             n_sent, n_checked, n_settings);
    $display("summary: %0d splats added, %0d dropped, %0d reads; clamping add checked at the top",
             n_added, n_dropped, n_reads);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bps_pkg.sv
hdl/bilinear_point_splat_core.sv
tb/sv/tb_bilinear_point_splat_core.sv
